// ===== design/aru_pkg.sv =====
package aru_pkg;

  // operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_SIZE   = 2'd2;

  // security grade codes
  localparam logic [1:0] GRADE_DANGER  = 2'd0;
  localparam logic [1:0] GRADE_WARNING = 2'd1;
  localparam logic [1:0] GRADE_SAFE    = 2'd2;

  // register indexes
  localparam logic REG_LINK_MODE     = 1'b0;
  localparam logic REG_STORAGE_READY = 1'b1;

  // ratio limits and thresholds
  localparam logic [4:0] RATIO_MIN     = 5'd5;
  localparam logic [4:0] RATIO_MAX     = 5'd30;
  localparam logic [4:0] RATIO_RESET   = 5'd15;
  localparam logic [4:0] RATIO_STEP_UP = 5'd5;
  localparam logic [4:0] DANGER_TOP    = 5'd10;
  localparam logic [4:0] WARNING_TOP   = 5'd20;
  localparam logic [7:0] LOOPS_HIGH    = 8'd5;
  localparam logic [7:0] LOOPS_LOW     = 8'd1;

  // size saturation
  localparam logic [63:0] PAYLOAD_LIMIT  = 64'd614891469123651720;
  localparam logic [57:0] SATURATED_SIZE = 58'd184467440737095516;

  // divide by 100: digits of 20 bits, reciprocal ceil(2^36/100)
  localparam int          DIGIT_W     = 20;
  localparam int          VAL_W       = 27;
  localparam int          RECIP_SHIFT = 36;
  localparam logic [29:0] RECIP       = 30'd687194768;
  // rounding term divide: reciprocal ceil(2^20/100)
  localparam int          LO_SHIFT    = 20;
  localparam logic [13:0] LO_RECIP    = 14'd10486;
  localparam logic [11:0] ROUND_HALF  = 12'd50;

  // per-item control that travels with the payload
  typedef struct packed {
    logic       is_size;
    logic       sat;
    logic [4:0] ratio;
    logic [1:0] grade;
    logic       gen;
  } ctl_t;

  // queue entry between front and back
  typedef struct packed {
    ctl_t        ctl;
    logic [59:0] payload;
  } item_t;

endpackage

// ===== design/aru_front.sv =====
module aru_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          s_tuser,   // operation
  input  logic [95:0]         s_tdata,   // requested_ratio, residual_error_count,
                                         // decoder_loop_count, payload_bytes
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                queue_full,
  output logic                push,
  output aru_pkg::item_t      push_item
);
  import aru_pkg::*;

  logic [4:0]  ratio;
  logic [4:0]  ratio_next;
  logic        link_mode;
  logic        storage_ready;
  logic [1:0]  op;
  logic [7:0]  req;
  logic [15:0] errs;
  logic [7:0]  loops;
  logic [63:0] payload;
  logic [5:0]  raised;
  logic [1:0]  grade;

  assign op      = s_tuser;
  assign req     = s_tdata[7:0];
  assign errs    = s_tdata[23:8];
  assign loops   = s_tdata[31:24];
  assign payload = s_tdata[95:32];

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;
  assign pready   = 1'b1;

  // register read
  assign prdata = {31'd0, (paddr[2] == REG_STORAGE_READY) ? storage_ready : link_mode};

  // ratio update for this word
  assign raised = {1'b0, ratio} + {1'b0, RATIO_STEP_UP};
  always_comb begin
    ratio_next = ratio;
    unique case (op)
      OP_SET: begin
        if (req < {3'd0, RATIO_MIN}) ratio_next = RATIO_MIN;
        else if (req > {3'd0, RATIO_MAX}) ratio_next = RATIO_MAX;
        else ratio_next = req[4:0];
      end
      OP_REPORT: begin
        if (errs != 16'd0 || loops >= LOOPS_HIGH) begin
          ratio_next = (raised > {1'b0, RATIO_MAX}) ? RATIO_MAX : raised[4:0];
        end else if (loops <= LOOPS_LOW && ratio > RATIO_MIN) begin
          ratio_next = ratio - 5'd1;
        end
      end
      default: ratio_next = ratio;
    endcase
  end

  // grade of the updated ratio
  always_comb begin
    if (ratio_next <= DANGER_TOP) grade = GRADE_DANGER;
    else if (ratio_next <= WARNING_TOP) grade = GRADE_WARNING;
    else grade = GRADE_SAFE;
  end

  // classified entry for the back end
  always_comb begin
    push_item.ctl.is_size = (op == OP_SIZE);
    push_item.ctl.sat     = (payload > PAYLOAD_LIMIT);
    push_item.ctl.ratio   = ratio_next;
    push_item.ctl.grade   = grade;
    push_item.ctl.gen     = link_mode | storage_ready;
    push_item.payload     = payload[59:0];
  end

  // ratio state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio         <= RATIO_RESET;
      link_mode     <= 1'b0;
      storage_ready <= 1'b1;
    end else begin
      if (push) ratio <= ratio_next;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LINK_MODE) link_mode <= pwdata[0];
        else storage_ready <= pwdata[0];
      end
    end
  end

endmodule

// ===== design/aru_queue.sv =====
module aru_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aru_pkg::item_t push_item,
  input  logic           pop,
  output aru_pkg::item_t head,
  output logic           full,
  output logic           empty
);
  import aru_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign head   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ===== design/aru_back.sv =====
module aru_back (
  input  logic           clk,
  input  logic           rst,
  input  aru_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [71:0]    m_tdata   // redundancy_bytes, ratio_now, security_grade,
                                   // generate_flag, zero fill
);
  import aru_pkg::*;

  localparam int STAGES = 8;

  logic [STAGES-1:0] valid;
  logic              adv;
  ctl_t              ctl [STAGES];

  // stage registers
  logic [VAL_W-1:0]     v0, v1, v2;
  logic [DIGIT_W-1:0]   q0, q1, q2;
  logic [39:0]          p0, p1;
  logic [19:0]          p2, p3;
  logic [6:0]           r0, r1, r2;
  logic [DIGIT_W-1:0]   hi1, hi2;
  logic [2*DIGIT_W-1:0] hi3, hi4;
  logic [3*DIGIT_W-1:0] hi5;
  logic [57:0]          hiprod;
  logic [11:0]          lop;
  logic [57:0]          size_out;

  // combinational stage logic
  logic [VAL_W-1:0]    v0_in, v1_in, v2_in;
  logic [56:0]         m0, m1, m2;
  logic [VAL_W-1:0]    q0x100, q1x100, q2x100;
  logic [64:0]         hiprod_full;
  logic [11:0]         lop_in;
  logic [25:0]         lq_full;
  logic [57:0]         size_in;

  assign adv      = !valid[STAGES-1] || m_tready;
  assign pop      = adv && head_valid;
  assign m_tvalid = valid[STAGES-1];

  // long division by 100, one 20-bit digit per multiply and remainder pair
  assign v0_in = {7'd0, head.payload[59:40]};
  assign m0    = 57'(v0_in) * 57'(RECIP);
  assign q0x100 = {1'b0, q0, 6'd0} + {2'd0, q0, 5'd0} + {5'd0, q0, 2'd0};

  assign v1_in = {r0, p1[39:20]};
  assign m1    = 57'(v1_in) * 57'(RECIP);
  assign q1x100 = {1'b0, q1, 6'd0} + {2'd0, q1, 5'd0} + {5'd0, q1, 2'd0};

  assign v2_in = {r1, p3};
  assign m2    = 57'(v2_in) * 57'(RECIP);
  assign q2x100 = {1'b0, q2, 6'd0} + {2'd0, q2, 5'd0} + {5'd0, q2, 2'd0};

  // quotient times ratio, remainder times ratio plus rounding half
  assign hiprod_full = 65'(hi5) * 65'(ctl[5].ratio);
  assign lop_in      = 12'(r2) * 12'(ctl[5].ratio) + ROUND_HALF;
  assign lq_full     = 26'(lop) * 26'(LO_RECIP);

  // final selection
  always_comb begin
    if (!ctl[6].is_size) size_in = '0;
    else if (ctl[6].sat) size_in = SATURATED_SIZE;
    else size_in = hiprod + 58'(lq_full[25:LO_SHIFT]);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[STAGES-2:0], head_valid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= head.ctl;
      for (int i = 1; i < STAGES; i++) ctl[i] <= ctl[i-1];

      v0 <= v0_in;
      q0 <= m0[RECIP_SHIFT +: DIGIT_W];
      p0 <= head.payload[39:0];

      r0  <= 7'(v0 - q0x100);
      hi1 <= q0;
      p1  <= p0;

      v1  <= v1_in;
      q1  <= m1[RECIP_SHIFT +: DIGIT_W];
      hi2 <= hi1;
      p2  <= p1[19:0];

      r1  <= 7'(v1 - q1x100);
      hi3 <= {hi2, q1};
      p3  <= p2;

      v2  <= v2_in;
      q2  <= m2[RECIP_SHIFT +: DIGIT_W];
      hi4 <= hi3;

      r2  <= 7'(v2 - q2x100);
      hi5 <= {hi4, q2};

      hiprod <= hiprod_full[57:0];
      lop    <= lop_in;

      size_out <= size_in;
    end
  end

  assign m_tdata = {6'd0, ctl[STAGES-1].gen, ctl[STAGES-1].grade, ctl[STAGES-1].ratio,
                    size_out};

endmodule

// ===== design/adaptive_redundancy_ratio_unit.sv =====
// Adaptive redundancy ratio unit: keeps a redundancy percentage between 5 and 30
// (15 after reset) that set and report words adjust, and turns size words into
// round(payload_bytes * ratio / 100), saturated for very large payloads. Every
// word accepted gives exactly one result word carrying the ratio after that
// word's update, its security grade and the generate flag. The block takes one
// word per cycle and returns one result per cycle while the queue has room and
// the output is not stalled; results come from the back-end pipeline that divides
// by 100 in three 20-bit digits, each a reciprocal multiply stage and a remainder
// stage, then two stages for the ratio products and rounding. A small queue between
// the front end and that pipeline absorbs downstream stalls. Register link_mode
// sits at address 0 and storage_ready at address 4; write them only while idle.
module adaptive_redundancy_ratio_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // operation
  input  logic [95:0] s_tdata,   // requested_ratio[7:0], residual_error_count[23:8],
                                 // decoder_loop_count[31:24], payload_bytes[95:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // redundancy_bytes[57:0], ratio_now[62:58],
                                 // security_grade[64:63], generate_flag[65], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aru_pkg::*;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  queue_empty;
  item_t head;
  logic  pop;

  // front end: ratio state, configuration, classification
  aru_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // decoupling queue
  aru_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // back end: size pipeline and output register
  aru_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!queue_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ===== design/aru_checker.sv =====
module aru_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);
  import aru_pkg::*;

  logic [4:0] ratio_f;
  logic [1:0] grade_f;

  assign ratio_f = m_tdata[62:58];
  assign grade_f = m_tdata[64:63];

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // ratio stays in range
  a_ratio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ratio_f >= RATIO_MIN && ratio_f <= RATIO_MAX)
    else $error("ratio out of range");

  // grade matches the ratio it travels with
  a_grade: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (ratio_f <= DANGER_TOP && grade_f == GRADE_DANGER) ||
                 (ratio_f > DANGER_TOP && ratio_f <= WARNING_TOP &&
                  grade_f == GRADE_WARNING) ||
                 (ratio_f > WARNING_TOP && grade_f == GRADE_SAFE))
    else $error("grade does not match ratio");

  // size never exceeds the saturation value and the fill bits stay zero
  a_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[57:0] <= SATURATED_SIZE && m_tdata[71:66] == 6'd0)
    else $error("size above saturation or fill bits set");

endmodule

bind adaptive_redundancy_ratio_unit aru_checker u_aru_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
